// ===== sv/lnr_pkg.sv =====
package lnr_pkg;

    localparam int MAX_ROW = 64;
    localparam int IDX_W   = $clog2(MAX_ROW);
    localparam int CNT_W   = IDX_W + 1;
    localparam int DIV_W   = 52;
    localparam int DVS_W   = 34;
    localparam int STEP_W  = 6;

    localparam logic [1:0] REG_ROW_LENGTH  = 2'd0;
    localparam logic [1:0] REG_EPS_VALUE   = 2'd1;
    localparam logic [1:0] REG_BETA_ENABLE = 2'd2;

    typedef struct packed {
        logic signed [15:0] x_value;
        logic signed [15:0] gamma_value;
        logic signed [15:0] beta_value;
    } lnr_in_t;

    typedef struct packed {
        logic signed [15:0] y_value;
        logic               row_last;
    } lnr_out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_V_RD,
        ST_V_DEV,
        ST_V_SQ,
        ST_V_ACC,
        ST_N2,
        ST_N3,
        ST_DIV_V,
        ST_WAIT_V,
        ST_CHK_V,
        ST_WAIT_I,
        ST_SQRT,
        ST_O_RD,
        ST_O_DEV,
        ST_O_M1,
        ST_O_M2,
        ST_O_DIV,
        ST_O_WAIT
    } lnr_state_t;

    typedef enum logic [1:0] {
        DIV_VAR,
        DIV_INV,
        DIV_OUT
    } lnr_div_sel_t;

    typedef struct packed {
        logic         load;
        logic         idx_clr;
        logic         idx_inc;
        logic         rd;
        logic         dev;
        logic         sq;
        logic         acc;
        logic         n2;
        logic         n3;
        logic         div_start;
        lnr_div_sel_t div_sel;
        logic         take_var;
        logic         inv_sat;
        logic         sqrt_init;
        logic         sqrt_step;
        logic         take_inv;
        logic         mul1;
        logic         mul2;
        logic         emit;
        logic         row_end;
    } lnr_cmd_t;

    typedef struct packed {
        logic row_close;
        logic idx_last;
        logic div_done;
        logic v_zero;
        logic sqrt_run;
    } lnr_status_t;

endpackage

// ===== sv/lnr_div.sv =====
module lnr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lnr_pkg::DIV_W-1:0]   dividend,
    input  logic [lnr_pkg::DVS_W-1:0]   divisor,
    input  logic [lnr_pkg::STEP_W-1:0]  steps,
    output logic                        done,
    output logic [lnr_pkg::DIV_W-1:0]   quotient,
    output logic [lnr_pkg::DVS_W-1:0]   remainder
);

    logic [lnr_pkg::DVS_W-1:0]  rem_reg;
    logic [lnr_pkg::DIV_W-1:0]  quo_reg;
    logic [lnr_pkg::DVS_W-1:0]  dvs_reg;
    logic [lnr_pkg::STEP_W-1:0] cnt_reg;
    logic                       run_reg;
    logic                       done_reg;
    logic [lnr_pkg::DVS_W:0]    trial;
    logic                       fits;

    assign trial = {rem_reg, quo_reg[lnr_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= steps;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == lnr_pkg::STEP_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? lnr_pkg::DVS_W'(trial - {1'b0, dvs_reg})
                            : trial[lnr_pkg::DVS_W-1:0];
            quo_reg <= {quo_reg[lnr_pkg::DIV_W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== sv/lnr_dp.sv =====
module lnr_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lnr_pkg::lnr_cmd_t     cmd,
    output lnr_pkg::lnr_status_t  status,
    input  lnr_pkg::lnr_in_t      item,
    input  logic [6:0]            row_length,
    input  logic [15:0]           eps_value,
    input  logic                  beta_enable,
    output logic                  result_strobe,
    output lnr_pkg::lnr_out_t     result
);

    logic [47:0] mem [lnr_pkg::MAX_ROW];
    logic [47:0] rd_reg;

    logic [lnr_pkg::CNT_W-1:0] count_reg;
    logic [lnr_pkg::CNT_W-1:0] n_reg;
    logic [lnr_pkg::IDX_W-1:0] idx_reg;
    logic signed [22:0]        sum_reg;
    logic [lnr_pkg::CNT_W-1:0] eff;
    logic [lnr_pkg::CNT_W-1:0] count_next;

    logic signed [23:0] d_reg;
    logic [44:0]        sq_reg;
    logic [50:0]        sumsq_reg;
    logic [12:0]        n2_reg;
    logic [18:0]        n3_reg;
    logic [33:0]        v_reg;
    logic [15:0]        inv_reg;
    logic signed [15:0] g_reg;
    logic signed [15:0] b_reg;
    logic signed [40:0] p1_reg;
    logic signed [56:0] p2_reg;

    logic [49:0] sa_reg;
    logic [49:0] sres_reg;
    logic [49:0] sbit_reg;
    logic [49:0] ssum;

    logic signed [7:0]  n_s;
    logic signed [23:0] nx;
    logic signed [47:0] sq_full;
    logic signed [15:0] rd_x;

    logic [lnr_pkg::DIV_W-1:0]  div_dividend;
    logic [lnr_pkg::DVS_W-1:0]  div_divisor;
    logic [lnr_pkg::STEP_W-1:0] div_steps;
    logic                       div_done;
    logic [lnr_pkg::DIV_W-1:0]  div_quo;
    logic [lnr_pkg::DVS_W-1:0]  div_rem;

    logic signed [28:0] a_val;
    logic               a_neg;
    logic [28:0]        a_mag;
    logic signed [29:0] q_adj;
    logic signed [30:0] y_sum;
    logic signed [15:0] y_sat;

    logic               strobe_reg;
    lnr_pkg::lnr_out_t  result_reg;

    always_comb
    begin
        priority if (row_length == 7'd0)
            eff = lnr_pkg::CNT_W'(1);
        else if (row_length > 7'(lnr_pkg::MAX_ROW))
            eff = lnr_pkg::CNT_W'(lnr_pkg::MAX_ROW);
        else
            eff = lnr_pkg::CNT_W'(row_length);
    end

    assign count_next = count_reg + 1'b1;

    assign rd_x    = rd_reg[47:32];
    assign n_s     = $signed({1'b0, n_reg});
    assign nx      = 24'(n_s) * 24'(rd_x);
    assign sq_full = 48'(d_reg) * 48'(d_reg);
    assign ssum    = sres_reg + sbit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            mem[count_reg[lnr_pkg::IDX_W-1:0]] <= {item.x_value, item.gamma_value,
                                                  item.beta_value};
        if (cmd.rd)
            rd_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            idx_reg   <= '0;
            n_reg     <= lnr_pkg::CNT_W'(1);
        end
        else
        begin
            if (cmd.load)
            begin
                count_reg <= count_next;
                n_reg     <= count_next;
                sum_reg   <= sum_reg + 23'(item.x_value);
            end
            else if (cmd.row_end)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                sumsq_reg <= '0;
            end
            if (cmd.acc)
                sumsq_reg <= sumsq_reg + 51'(sq_reg);
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dev)
        begin
            d_reg <= nx - 24'(sum_reg);
            g_reg <= rd_reg[31:16];
            b_reg <= rd_reg[15:0];
        end
        if (cmd.sq)
            sq_reg <= sq_full[44:0];
        if (cmd.n2)
            n2_reg <= 13'(n_reg * n_reg);
        if (cmd.n3)
            n3_reg <= 19'(n2_reg * n_reg);
        if (cmd.take_var)
            v_reg <= 34'(div_quo[32:0]) + 34'(eps_value);
        if (cmd.inv_sat)
            inv_reg <= 16'hFFFF;
        else if (cmd.take_inv)
            inv_reg <= (sres_reg > 50'd65535) ? 16'hFFFF : sres_reg[15:0];
        if (cmd.sqrt_init)
        begin
            sa_reg   <= 50'(div_quo[48:0]);
            sres_reg <= '0;
            sbit_reg <= 50'd1 << 48;
        end
        else if (cmd.sqrt_step)
        begin
            if (sa_reg >= ssum)
            begin
                sa_reg   <= sa_reg - ssum;
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end
            else
            begin
                sres_reg <= sres_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
        if (cmd.mul1)
            p1_reg <= 41'(d_reg) * 41'($signed({1'b0, inv_reg}));
        if (cmd.mul2)
            p2_reg <= 57'(p1_reg) * 57'(g_reg);
    end

    assign a_val = p2_reg[56:28];
    assign a_neg = a_val[28];
    assign a_mag = a_neg ? 29'(-a_val) : 29'(a_val);

    always_comb
    begin
        unique case (cmd.div_sel)
            lnr_pkg::DIV_VAR:
            begin
                div_dividend = {sumsq_reg, 1'b0};
                div_divisor  = 34'(n3_reg);
                div_steps    = 6'd51;
            end
            lnr_pkg::DIV_INV:
            begin
                div_dividend = 52'd1 << 51;
                div_divisor  = v_reg;
                div_steps    = 6'd49;
            end
            lnr_pkg::DIV_OUT:
            begin
                div_dividend = {a_mag, 23'd0};
                div_divisor  = 34'(n_reg);
                div_steps    = 6'd29;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = 34'd1;
                div_steps    = 6'd1;
            end
        endcase
    end

    lnr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .steps     (div_steps),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        if (a_neg)
            q_adj = -$signed({1'b0, div_quo[28:0]}) - 30'(div_rem != '0);
        else
            q_adj = $signed({1'b0, div_quo[28:0]});
        y_sum = 31'(q_adj) + (beta_enable ? 31'(b_reg) : 31'sd0);
        priority if (y_sum > 31'sd32767)
            y_sat = 16'sh7FFF;
        else if (y_sum < -31'sd32768)
            y_sat = -16'sh8000;
        else
            y_sat = y_sum[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.y_value  <= y_sat;
            result_reg.row_last <= status.idx_last;
        end
    end

    assign status.row_close = count_next >= eff;
    assign status.idx_last  = (lnr_pkg::CNT_W'(idx_reg) + 1'b1) == n_reg;
    assign status.div_done  = div_done;
    assign status.v_zero    = v_reg == '0;
    assign status.sqrt_run  = sbit_reg != '0;

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

// ===== sv/lnr_ctrl.sv =====
module lnr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  lnr_pkg::lnr_status_t status,
    output lnr_pkg::lnr_cmd_t    cmd
);

    lnr_pkg::lnr_state_t state_reg;
    lnr_pkg::lnr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lnr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = lnr_pkg::DIV_VAR;
        unique case (state_reg)
            lnr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (status.row_close)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = lnr_pkg::ST_V_RD;
                    end
                end
            end
            lnr_pkg::ST_V_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = lnr_pkg::ST_V_DEV;
            end
            lnr_pkg::ST_V_DEV:
            begin
                cmd.dev    = 1'b1;
                state_next = lnr_pkg::ST_V_SQ;
            end
            lnr_pkg::ST_V_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = lnr_pkg::ST_V_ACC;
            end
            lnr_pkg::ST_V_ACC:
            begin
                cmd.acc = 1'b1;
                if (status.idx_last)
                    state_next = lnr_pkg::ST_N2;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = lnr_pkg::ST_V_RD;
                end
            end
            lnr_pkg::ST_N2:
            begin
                cmd.n2     = 1'b1;
                state_next = lnr_pkg::ST_N3;
            end
            lnr_pkg::ST_N3:
            begin
                cmd.n3     = 1'b1;
                state_next = lnr_pkg::ST_DIV_V;
            end
            lnr_pkg::ST_DIV_V:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = lnr_pkg::DIV_VAR;
                state_next    = lnr_pkg::ST_WAIT_V;
            end
            lnr_pkg::ST_WAIT_V:
            begin
                if (status.div_done)
                begin
                    cmd.take_var = 1'b1;
                    state_next   = lnr_pkg::ST_CHK_V;
                end
            end
            lnr_pkg::ST_CHK_V:
            begin
                if (status.v_zero)
                begin
                    cmd.inv_sat = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = lnr_pkg::ST_O_RD;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = lnr_pkg::DIV_INV;
                    state_next    = lnr_pkg::ST_WAIT_I;
                end
            end
            lnr_pkg::ST_WAIT_I:
            begin
                if (status.div_done)
                begin
                    cmd.sqrt_init = 1'b1;
                    state_next    = lnr_pkg::ST_SQRT;
                end
            end
            lnr_pkg::ST_SQRT:
            begin
                if (status.sqrt_run)
                    cmd.sqrt_step = 1'b1;
                else
                begin
                    cmd.take_inv = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    state_next   = lnr_pkg::ST_O_RD;
                end
            end
            lnr_pkg::ST_O_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = lnr_pkg::ST_O_DEV;
            end
            lnr_pkg::ST_O_DEV:
            begin
                cmd.dev    = 1'b1;
                state_next = lnr_pkg::ST_O_M1;
            end
            lnr_pkg::ST_O_M1:
            begin
                cmd.mul1   = 1'b1;
                state_next = lnr_pkg::ST_O_M2;
            end
            lnr_pkg::ST_O_M2:
            begin
                cmd.mul2   = 1'b1;
                state_next = lnr_pkg::ST_O_DIV;
            end
            lnr_pkg::ST_O_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = lnr_pkg::DIV_OUT;
                state_next    = lnr_pkg::ST_O_WAIT;
            end
            lnr_pkg::ST_O_WAIT:
            begin
                cmd.div_sel = lnr_pkg::DIV_OUT;
                if (status.div_done)
                begin
                    cmd.emit = 1'b1;
                    if (status.idx_last)
                    begin
                        cmd.row_end = 1'b1;
                        state_next  = lnr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = lnr_pkg::ST_O_RD;
                    end
                end
            end
            default:
            begin
                state_next = lnr_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = state_reg != lnr_pkg::ST_IDLE;

endmodule

// ===== sv/layer_norm_row.sv =====
// Layer normalization over one row of up to 64 Q8.8 elements.
// Input: pulse start with item (x, gamma, beta) while busy is low; that is a
// transfer, one element per cycle while the row fills.
// The transfer that completes the row (count reaches row_length; 0 counts as 1,
// above 64 as 64) raises busy. Row processing: a variance pass per element
// (read, deviation, square, accumulate), cube and variance divide, reciprocal
// divide and square root (skipped when variance plus epsilon is zero), then
// one result per element from the 29-step serial divider that applies 1/N;
// busy falls with the last result.
// Results appear on result for one cycle with result_strobe high, row_last on
// the final one; the receiver cannot stall and must take each one.
// Configuration: APB, row_length at 0x0, eps_value at 0x4, beta_enable at
// 0x8; write only while busy is low and no row is half loaded.
// Reset clears the element count and the row sum and loads row_length 64,
// eps_value 1, beta_enable 0; the row buffer is not cleared.
module layer_norm_row (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  lnr_pkg::lnr_in_t    item,
    output logic                result_strobe,
    output lnr_pkg::lnr_out_t   result
);

    logic [6:0]  row_length_reg;
    logic [15:0] eps_value_reg;
    logic        beta_enable_reg;
    logic        wr_en;

    lnr_pkg::lnr_cmd_t    cmd;
    lnr_pkg::lnr_status_t status;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg  <= 7'd64;
            eps_value_reg   <= 16'd1;
            beta_enable_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                lnr_pkg::REG_ROW_LENGTH:  row_length_reg  <= pwdata[6:0];
                lnr_pkg::REG_EPS_VALUE:   eps_value_reg   <= pwdata[15:0];
                lnr_pkg::REG_BETA_ENABLE: beta_enable_reg <= pwdata[0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            lnr_pkg::REG_ROW_LENGTH:  prdata = 32'(row_length_reg);
            lnr_pkg::REG_EPS_VALUE:   prdata = 32'(eps_value_reg);
            lnr_pkg::REG_BETA_ENABLE: prdata = 32'(beta_enable_reg);
            default:                  prdata = '0;
        endcase
    end

    lnr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    lnr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .item          (item),
        .row_length    (row_length_reg),
        .eps_value     (eps_value_reg),
        .beta_enable   (beta_enable_reg),
        .result_strobe (result_strobe),
        .result        (result)
    );

    a_no_strobe_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !result_strobe)
        else $error("result strobe right after an input transfer");

    a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe)
        else $error("results on consecutive cycles");

    a_mid_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.row_last) |-> busy)
        else $error("block idle before the last result of a row");

endmodule
